/* design/srt_pkg.sv */
// Shared types and constants for the receive-side sequence tracker.
// No dependencies; compile this file first.
package srt_pkg;

  typedef enum logic [2:0] {
    V_DELIVER     = 3'd0,
    V_DELIVER_ACK = 3'd1,
    V_DROP        = 3'd2,
    V_CHECK       = 3'd3,
    V_SET         = 3'd4
  } verdict_t;

  localparam logic       ACT_DATA   = 1'b0;
  localparam logic       ACT_PORT0  = 1'b1;
  localparam logic [7:0] LEN_CHECK  = 8'd0;
  localparam logic [7:0] LEN_SET    = 8'd2;
  localparam logic [7:0] SET_OPCODE = 8'h00;
  localparam logic [7:0] SEQ_MASK   = 8'h7f;
  localparam logic [7:0] SEQ_NONE   = 8'h80;
  localparam logic [7:0] ADDR_ANY   = 8'hff;
  localparam logic [7:0] REPLY_NONE = 8'h00;

  typedef struct packed {
    logic [7:0] mac;
    logic [7:0] net;
    logic [7:0] seq;
  } rec_t;

  localparam rec_t RESET_REC = '{mac: ADDR_ANY, net: ADDR_ANY, seq: SEQ_NONE};

  typedef struct packed {
    logic       action;
    logic [7:0] req_len;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [6:0] seq_num;
    logic       req_ack;
    logic       net_addressed;
    logic [7:0] src_mac;
    logic [7:0] src_net;
  } in_item_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] reply_byte;
    logic       record_hit;
  } out_item_t;

endpackage

/* design/srt_if.sv */
// Valid/ready channel interfaces for packet requests and verdicts.
// Depends on srt_pkg for the payload structs.
interface srt_in_if;
  import srt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/seq_receive_tracker_unit.sv */
// Receive-side sequence tracker, top level.
// Depends on srt_pkg, srt_if and srt_records.
//
// Usage: each request on pkt is either a sequenced data packet or a port-0
// request. The block answers every request with exactly one verdict on
// result: deliver, deliver plus ack, drop, check reply or set reply.
// Peer records are kept in a store ordered by recency of use.
//
// Timing: a request is first matched by a scan that reads one record per
// cycle through the store's single read port, then decided in S_DECIDE. A
// request that changes a record (a delivered data packet or a set) runs a
// second sweep that rewrites every record's recency rank; other requests
// go straight from S_DECIDE to S_DONE, where the verdict is registered.
// pkt.ready is high only while the block waits for a request, and the next
// request can be taken the cycle after the verdict is registered.
//
// Reset: every record reads as mac 255, net 255, sequence 0x80, ranked by
// index; this takes effect at once. If result is stalled, a finished verdict
// waits in the output register; a further request is still accepted and
// processed, and holds in its last step until the output register frees up.
module seq_receive_tracker_unit #(
  parameter int RECORDS = 8
) (
  input logic     clk,
  input logic     rst,
  srt_in_if.sink  pkt,
  srt_out_if.source result
);
  import srt_pkg::*;

  localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CW = $clog2(RECORDS + 1);
  localparam logic [CW-1:0] LAST = CW'(RECORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [IW-1:0] data_idx;
  in_item_t      item;

  logic          hit;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] best_rank;
  logic [7:0]    best_seq;
  logic [IW-1:0] old_idx;
  logic [IW-1:0] old_rank;

  logic [IW-1:0] upd_tgt;
  logic [IW-1:0] upd_rank;
  logic [7:0]    upd_seq;
  logic          upd_take;

  out_item_t     pend_res;
  out_item_t     res;
  logic          out_valid;

  rec_t          rd_rec;
  logic [IW-1:0] rd_rank;
  logic          wr_en;
  rec_t          wr_rec;
  logic [IW-1:0] wr_rank;

  logic          issue;
  logic          cmp_match;
  logic          cmp_better;
  logic          cmp_older;
  logic          is_tgt;

  out_item_t     dec_res;
  logic          dec_upd;
  logic [IW-1:0] dec_tgt;
  logic [IW-1:0] dec_rank;
  logic [7:0]    dec_seq;
  logic          dec_take;
  logic [7:0]    seq_adv;

  srt_records #(.RECORDS(RECORDS)) u_records (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx[IW-1:0]),
    .rd_rec  (rd_rec),
    .rd_rank (rd_rank),
    .wr_en   (wr_en),
    .wr_addr (data_idx),
    .wr_rec  (wr_rec),
    .wr_rank (wr_rank)
  );

  assign issue = (state == S_SCAN || state == S_UPDATE) && (idx != LAST);

  // Shared compare unit: one record per cycle during the scan.
  always_comb begin
    cmp_match  = (rd_rec.mac == item.src_mac) &&
                 (item.net_addressed ? (rd_rec.net == item.src_net)
                                     : (rd_rec.net == ADDR_ANY));
    cmp_better = cmp_match && (!hit || (rd_rank < best_rank));
    cmp_older  = (data_idx == '0) || (rd_rank > old_rank);
  end

  // Rank rewrite during the update sweep: the target goes to the front and
  // everything that was more recent than it moves back by one.
  always_comb begin
    is_tgt  = (data_idx == upd_tgt);
    wr_en   = (state == S_UPDATE) && rd_pend;
    wr_rec  = rd_rec;
    wr_rank = rd_rank;
    if (is_tgt) begin
      wr_rank    = '0;
      wr_rec.seq = upd_seq;
      if (upd_take) begin
        wr_rec.mac = item.src_mac;
        wr_rec.net = item.net_addressed ? item.src_net : ADDR_ANY;
      end
    end else if (rd_rank < upd_rank) begin
      wr_rank = rd_rank + IW'(1);
    end
  end

  always_comb begin
    seq_adv                = (best_seq + 8'd1) & SEQ_MASK;
    dec_res.verdict        = V_DROP;
    dec_res.reply_byte     = REPLY_NONE;
    dec_res.record_hit     = hit;
    dec_upd                = 1'b0;
    dec_tgt                = best_idx;
    dec_rank               = best_rank;
    dec_seq                = seq_adv;
    dec_take               = 1'b0;
    if (item.action == ACT_DATA) begin
      if (hit && (best_seq == {1'b0, item.seq_num})) begin
        dec_upd = 1'b1;
        if (item.req_ack) begin
          dec_res.verdict    = V_DELIVER_ACK;
          dec_res.reply_byte = seq_adv;
        end else begin
          dec_res.verdict = V_DELIVER;
        end
      end
    end else if (item.req_len == LEN_CHECK) begin
      dec_res.verdict    = V_CHECK;
      dec_res.reply_byte = hit ? best_seq : SEQ_NONE;
    end else if ((item.req_len == LEN_SET) && (item.first_byte == SET_OPCODE)) begin
      // An unknown peer takes over the least recently used record.
      dec_res.verdict = V_SET;
      dec_upd         = 1'b1;
      dec_seq         = item.second_byte;
      dec_take        = !hit;
      if (!hit) begin
        dec_tgt  = old_idx;
        dec_rank = old_rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        idx      <= idx + CW'(1);
        data_idx <= idx[IW-1:0];
      end
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (pkt.valid) begin
            item    <= pkt.data;
            idx     <= '0;
            hit     <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (cmp_better) begin
              hit       <= 1'b1;
              best_idx  <= data_idx;
              best_rank <= rd_rank;
              best_seq  <= rd_rec.seq;
            end
            if (cmp_older) begin
              old_idx  <= data_idx;
              old_rank <= rd_rank;
            end
            if (!issue) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          pend_res <= dec_res;
          upd_tgt  <= dec_tgt;
          upd_rank <= dec_rank;
          upd_seq  <= dec_seq;
          upd_take <= dec_take;
          idx      <= '0;
          state    <= dec_upd ? S_UPDATE : S_DONE;
        end
        S_UPDATE: begin
          if (rd_pend && !issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            res       <= pend_res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pkt.ready    = (state == S_IDLE) && !rst;
  assign result.valid = out_valid;
  assign result.data  = res;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready) |=> !pkt.ready)
    else $error("tracker ready again right after taking a request");

  a_deliver_has_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.verdict == V_DELIVER || res.verdict == V_DELIVER_ACK))
      |-> res.record_hit)
    else $error("delivery verdict without a matching record");

  a_reply_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.verdict == V_DELIVER || res.verdict == V_DROP ||
                   res.verdict == V_SET)) |-> (res.reply_byte == REPLY_NONE))
    else $error("reply byte set on a verdict that carries none");

  a_ack_seq_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.verdict == V_DELIVER_ACK) |-> !res.reply_byte[7])
    else $error("ack sequence outside seven bits");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(state == S_UPDATE || state == S_DECIDE))
    else $error("record write outside the update sweep");

endmodule

/* design/srt_records.sv */
// Peer record store: one read port with registered data, one write port.
// Entries never written read back as the reset record, with rank equal to the index.
// Depends on srt_pkg.
module srt_records #(
  parameter int RECORDS = 8,
  localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [IW-1:0]  rd_addr,
  output srt_pkg::rec_t  rd_rec,
  output logic [IW-1:0]  rd_rank,
  input  logic           wr_en,
  input  logic [IW-1:0]  wr_addr,
  input  srt_pkg::rec_t  wr_rec,
  input  logic [IW-1:0]  wr_rank
);
  import srt_pkg::*;

  rec_t               mem_rec  [RECORDS];
  logic [IW-1:0]      mem_rank [RECORDS];
  logic [RECORDS-1:0] filled;

  rec_t          rd_rec_q;
  logic [IW-1:0] rd_rank_q;
  logic [IW-1:0] rd_addr_q;
  logic          rd_filled_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_rec[wr_addr]  <= wr_rec;
      mem_rank[wr_addr] <= wr_rank;
    end
    rd_rec_q    <= mem_rec[rd_addr];
    rd_rank_q   <= mem_rank[rd_addr];
    rd_filled_q <= filled[rd_addr];
    rd_addr_q   <= rd_addr;
  end

  assign rd_rec  = rd_filled_q ? rd_rec_q : RESET_REC;
  assign rd_rank = rd_filled_q ? rd_rank_q : rd_addr_q;

endmodule
